@@ rtl/s3i_pkg.sv @@
// Package for the symmetric 3x3 inverse: widths, the pipeline beat struct.
// No dependencies.
package s3i_pkg;
    localparam int DW   = 32;
    localparam int FB   = 16;
    localparam int PW   = 2 * DW + 1;        // cofactor width
    localparam int DETW = 3 * DW + 3;        // determinant width
    localparam int NW   = PW + 2 * FB + 2;   // numerator magnitude width
    localparam int QW   = NW;                // quotient width
    localparam int NSTEP = QW;               // one quotient bit per cell
    localparam int NENT = 6;

    // Split of the determinant products into two narrow multiplies.
    localparam int CLW  = PW - DW;           // low cofactor slice, unsigned
    localparam int PPW  = 2 * DW;            // entry times high slice
    localparam int PLW  = DW + CLW + 1;      // entry times low slice
    localparam int HSW  = PPW + 2;           // sum of three high products
    localparam int LSW  = PLW + 2;           // sum of three low products

    typedef logic signed [DW-1:0] ent_t;

    typedef struct packed {
        logic [NENT-1:0][NW-1:0] rem;
        logic [NENT-1:0][NW-1:0] num;
        logic [NENT-1:0][QW-1:0] quo;
        logic [NENT-1:0]         neg;
        logic [DETW:0]           den;
        logic                    sing;
        logic                    vld;
    } div_beat_t;
endpackage

@@ rtl/s3i_front.sv @@
// Front stages: products, cofactors, determinant, numerator setup.
// Depends on s3i_pkg.
module s3i_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  s3i_pkg::ent_t [5:0] a,
    output s3i_pkg::div_beat_t  beat
);
    import s3i_pkg::*;

    logic signed [PPW-1:0]  p_reg [12];
    logic signed [DW-1:0]   a1_reg [3];
    logic [5:0]             vld_reg;
    logic signed [PW-1:0]   cof2_reg [6];
    logic signed [DW-1:0]   a2_reg [3];
    logic signed [PPW-1:0]  ph3_reg [3];
    logic signed [PLW-1:0]  pl3_reg [3];
    logic signed [PW-1:0]   cof3_reg [6];
    logic signed [HSW-1:0]  hs4_reg;
    logic signed [LSW-1:0]  ls4_reg;
    logic signed [PW-1:0]   cof4_reg [6];
    logic signed [DETW-1:0] det_reg;
    logic signed [PW-1:0]   cof5_reg [6];
    logic [DETW-1:0]        det_mag;
    div_beat_t              beat_next;
    div_beat_t              beat_reg;

    // Valid bit of each front stage; the last one belongs to the outgoing beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_vld};
    end

    // Stage 1: the twelve entry products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // a: 0 xx,1 xy,2 xz,3 yy,4 yz,5 zz
            p_reg[0]  <= a[3] * a[5];  p_reg[1]  <= a[4] * a[4];
            p_reg[2]  <= a[2] * a[4];  p_reg[3]  <= a[1] * a[5];
            p_reg[4]  <= a[1] * a[4];  p_reg[5]  <= a[2] * a[3];
            p_reg[6]  <= a[0] * a[5];  p_reg[7]  <= a[2] * a[2];
            p_reg[8]  <= a[1] * a[2];  p_reg[9]  <= a[0] * a[4];
            p_reg[10] <= a[0] * a[3];  p_reg[11] <= a[1] * a[1];
            a1_reg[0] <= a[0]; a1_reg[1] <= a[1]; a1_reg[2] <= a[2];
            // Stage 2: cofactors.
            for (int k = 0; k < 6; k++)
                cof2_reg[k] <= PW'(p_reg[2*k]) - PW'(p_reg[2*k+1]);
            a2_reg <= a1_reg;
            // Stage 3: determinant terms as entry times high and low cofactor slices.
            for (int k = 0; k < 3; k++)
            begin
                ph3_reg[k] <= a2_reg[k] * $signed(cof2_reg[k][PW-1:CLW]);
                pl3_reg[k] <= a2_reg[k] * $signed({1'b0, cof2_reg[k][CLW-1:0]});
            end
            cof3_reg <= cof2_reg;
            // Stage 4: sums of the high and of the low slices.
            hs4_reg  <= HSW'(ph3_reg[0]) + HSW'(ph3_reg[1]) + HSW'(ph3_reg[2]);
            ls4_reg  <= LSW'(pl3_reg[0]) + LSW'(pl3_reg[1]) + LSW'(pl3_reg[2]);
            cof4_reg <= cof3_reg;
            // Stage 5: the determinant.
            det_reg  <= (DETW'(hs4_reg) <<< CLW) + DETW'(ls4_reg);
            cof5_reg <= cof4_reg;
            beat_reg <= beat_next;
        end
    end

    assign det_mag = det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);

    // Stage 6: rounded numerator |cof|*2^(2F+1)+|det| over 2|det|.
    always_comb
    begin
        logic [PW-1:0] cm;
        beat_next      = '0;
        beat_next.vld  = vld_reg[4];
        beat_next.sing = (det_reg == '0);
        beat_next.den  = {det_mag, 1'b0};
        for (int k = 0; k < NENT; k++)
        begin
            cm = cof5_reg[k][PW-1] ? PW'(-cof5_reg[k]) : PW'(cof5_reg[k]);
            beat_next.num[k] = (NW'(cm) << (2*FB+1)) + NW'(det_mag);
            beat_next.neg[k] = cof5_reg[k][PW-1] ^ det_reg[DETW-1];
        end
    end

    // Outgoing beat with its reset valid bit.
    always_comb
    begin
        beat     = beat_reg;
        beat.vld = vld_reg[5];
    end
endmodule

@@ rtl/s3i_div_cell.sv @@
// One restoring-division cell: one quotient bit for all six entries.
// Depends on s3i_pkg.
module s3i_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  s3i_pkg::div_beat_t d_in,
    output s3i_pkg::div_beat_t d_out
);
    import s3i_pkg::*;

    div_beat_t d_next;
    div_beat_t data_reg;
    logic      vld_reg;

    // Shift in the top numerator bit, subtract the divisor if it fits.
    always_comb
    begin
        logic [NW:0] r;
        d_next = d_in;
        for (int k = 0; k < NENT; k++)
        begin
            r = {d_in.rem[k], d_in.num[k][NW-1]};
            d_next.num[k] = {d_in.num[k][NW-2:0], 1'b0};
            if (r >= (NW+1)'(d_in.den))
            begin
                r = r - (NW+1)'(d_in.den);
                d_next.quo[k] = {d_in.quo[k][QW-2:0], 1'b1};
            end
            else
                d_next.quo[k] = {d_in.quo[k][QW-2:0], 1'b0};
            d_next.rem[k] = r[NW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= d_in.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= d_next;
    end

    // Outgoing beat with its reset valid bit.
    always_comb
    begin
        d_out     = data_reg;
        d_out.vld = vld_reg;
    end
endmodule

@@ rtl/symmetric_3x3_inverse_top.sv @@
// Top level of the symmetric 3x3 inverse: front stages, division chain, output.
// Depends on s3i_pkg, s3i_front, s3i_div_cell.
//
//  channel  direction  handshake         payload
//  input    in         in_valid/in_stall a_xx..a_zz
//  output   out        out_valid/out_stall inv_xx..inv_zz, singular, overflow
//
// One matrix per cycle while out_stall does not freeze the pipeline: six front stages,
// one restoring-division cell per quotient bit, one output register.
// Reset clears all valid bits; data registers are not reset.
// A result held under out_stall freezes the whole pipeline; in_stall follows it.
module symmetric_3x3_inverse_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  s3i_pkg::ent_t          a_xx, a_xy, a_xz, a_yy, a_yz, a_zz,
    output logic                   out_valid,
    input  logic                   out_stall,
    output s3i_pkg::ent_t          inv_xx, inv_xy, inv_xz, inv_yy, inv_yz, inv_zz,
    output logic                   singular,
    output logic                   overflow
);
    import s3i_pkg::*;

    logic      en;
    ent_t [5:0] a;
    div_beat_t chain [NSTEP+1];
    ent_t [5:0] inv_reg;
    ent_t [5:0] inv_next;
    logic      sing_reg, ovf_reg, vld_reg, ovf_next;

    assign en = !(vld_reg && out_stall);
    assign in_stall = !en;
    assign a = {a_zz, a_yz, a_yy, a_xz, a_xy, a_xx};

    s3i_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(in_valid), .a(a), .beat(chain[0])
    );

    // Row of division cells.
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cell
        s3i_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .d_in(chain[i]), .d_out(chain[i+1])
        );
    end

    // Saturation and sign; a singular result gets zero entries and no overflow.
    always_comb
    begin
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        ovf_next = 1'b0;
        for (int k = 0; k < NENT; k++)
        begin
            q = chain[NSTEP].quo[k];
            lim = (chain[NSTEP].neg[k] && q != '0) ? (QW'(1) << (DW-1))
                                                   : ((QW'(1) << (DW-1)) - QW'(1));
            if (q > lim)
            begin
                q = lim;
                ovf_next = 1'b1;
            end
            inv_next[k] = (chain[NSTEP].neg[k]) ? DW'(-q) : DW'(q);
            if (chain[NSTEP].sing)
                inv_next[k] = '0;
        end
        if (chain[NSTEP].sing)
            ovf_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= chain[NSTEP].vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg  <= inv_next;
            sing_reg <= chain[NSTEP].sing;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid = vld_reg;
    assign inv_xx = inv_reg[0]; assign inv_xy = inv_reg[1]; assign inv_xz = inv_reg[2];
    assign inv_yy = inv_reg[3]; assign inv_yz = inv_reg[4]; assign inv_zz = inv_reg[5];
    assign singular = sing_reg;
    assign overflow = ovf_reg;

    // A singular result carries no overflow and zero entries.
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !overflow && inv_xx == 0 && inv_zz == 0)
        else $error("singular result not clean");
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inv_xx) && $stable(overflow))
        else $error("stalled result changed");
    // The input side stalls exactly when the output holds a stalled beat.
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("backpressure mismatch");
endmodule
